@@ rtl/core/mot_pkg.sv @@
// Shared types and constants for the masked Otsu threshold core.
// No dependencies; the other files that use it refer to it by scoped names.
`default_nettype none
package mot_pkg;

    // Histogram bin counter width and derived arithmetic widths
    localparam int COUNT_BITS = 21;
    localparam int NUM_BINS   = 256;
    localparam int PIX_W      = 8;
    localparam int SUM_W      = COUNT_BITS + PIX_W;
    localparam int GAP_W      = COUNT_BITS + SUM_W;
    localparam int PROD_W     = 2 * COUNT_BITS;
    localparam int SQ_W       = 2 * GAP_W;
    localparam int CMP_W      = SQ_W + PROD_W;

    // Item queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             count;
        logic             last;
    } q_item_t;

endpackage
`default_nettype wire

@@ rtl/core/masked_otsu_threshold_core.sv @@
// Masked Otsu threshold core. Throughput: one pixel transfer per cycle while busy is low, until the last pixel.
// After the last pixel transfer the scan runs before done: for an empty mask it is skipped,
// else each of the 256 thresholds takes six serial multiplies, each of which ends early
// once the remaining multiplier bits are zero.
// busy holds from the last pixel until the done cycle, in which it drops.
// rst_n clears all control state and the histogram valid bits; done cannot be stalled.
`default_nettype none
module masked_otsu_threshold_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output      logic                      busy,
    input  wire logic [mot_pkg::PIX_W-1:0] pixel,
    input  wire logic                      in_mask,
    input  wire logic                      last_pixel,
    output      logic                      done,
    output      logic [mot_pkg::PIX_W-1:0] threshold,
    output      logic                      empty_mask
);

    mot_pkg::q_item_t q_item;
    logic             q_valid;
    logic             q_pop;
    logic             scan_done;

    mot_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .pixel      (pixel),
        .in_mask    (in_mask),
        .last_pixel (last_pixel),
        .busy       (busy),
        .q_item     (q_item),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .scan_done  (scan_done)
    );

    mot_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_item     (q_item),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .scan_done  (scan_done),
        .done       (done),
        .threshold  (threshold),
        .empty_mask (empty_mask)
    );

endmodule
`default_nettype wire

@@ rtl/core/mot_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read; read returns the old contents on a collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/core/mot_front.sv @@
// Front end: accepts pixel commands, applies the mask and count limit,
// and queues classified items for the back end. Depends on mot_pkg.
`default_nettype none
module mot_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [mot_pkg::PIX_W-1:0] pixel,
    input  wire logic                     in_mask,
    input  wire logic                     last_pixel,
    output      logic                     busy,
    output      mot_pkg::q_item_t         q_item,
    output      logic                     q_valid,
    input  wire logic                     q_pop,
    input  wire logic                     scan_done
);

    mot_pkg::q_item_t                   q_mem_reg [mot_pkg::QUEUE_DEPTH];
    logic [mot_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [mot_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [mot_pkg::QCNT_W-1:0]         cnt_reg, cnt_next;
    logic [mot_pkg::COUNT_BITS-1:0]     total_reg, total_next;
    logic                               pending_reg, pending_next;
    logic                               push;
    logic                               count_it;

    // Hold off new commands while an image is finishing or the queue is full
    assign busy     = pending_reg || (cnt_reg == mot_pkg::QCNT_W'(mot_pkg::QUEUE_DEPTH));
    assign push     = start && !busy;
    assign count_it = in_mask && (total_reg != mot_pkg::COUNT_MAX);
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = q_mem_reg[rd_ptr_reg];

    // Advance pointers, count and per-image state
    always_comb
    begin
        wr_ptr_next  = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next  = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next     = cnt_reg;
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        total_next   = total_reg;
        pending_next = pending_reg;
        if (push && last_pixel)
        begin
            total_next   = '0;
            pending_next = 1'b1;
        end
        else if (push && count_it)
        begin
            total_next = total_reg + 1'b1;
        end
        if (scan_done)
        begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            cnt_reg     <= '0;
            total_reg   <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            cnt_reg     <= cnt_next;
            total_reg   <= total_next;
            pending_reg <= pending_next;
        end
    end

    // Store the classified item on a transfer
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= '{pixel: pixel, count: count_it, last: last_pixel};
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/mot_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle,
// finishing early when the remaining multiplier bits are zero. Depends on mot_pkg.
`default_nettype none
module mot_mul (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [mot_pkg::SQ_W-1:0]  a,
    input  wire logic [mot_pkg::GAP_W-1:0] b,
    output      logic                      done,
    output      logic [mot_pkg::CMP_W-1:0] product
);

    logic [mot_pkg::CMP_W-1:0] acc_reg, acc_next;
    logic [mot_pkg::CMP_W-1:0] a_reg, a_next;
    logic [mot_pkg::GAP_W-1:0] b_reg, b_next;
    logic                      busy_reg, busy_next;

    assign done    = busy_reg && (b_reg == '0);
    assign product = acc_reg;

    // Load operands, then add and shift until the multiplier is used up
    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        busy_next = busy_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                acc_next  = '0;
                a_next    = mot_pkg::CMP_W'(a);
                b_next    = b;
                busy_next = 1'b1;
            end
        end
        else if (b_reg == '0)
        begin
            busy_next = 1'b0;
        end
        else
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next = a_reg << 1;
            b_next = b_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            busy_reg <= busy_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/mot_back.sv @@
// Back end: histogram read-modify-write from the item queue, then the
// threshold scan with a shared serial multiplier. Depends on mot_pkg, mot_ram, mot_mul.
`default_nettype none
module mot_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire mot_pkg::q_item_t          q_item,
    input  wire logic                      q_valid,
    output      logic                      q_pop,
    output      logic                      scan_done,
    output      logic                      done,
    output      logic [mot_pkg::PIX_W-1:0] threshold,
    output      logic                      empty_mask
);

    localparam logic [3:0] ST_HIST = 4'd0;
    localparam logic [3:0] ST_MX   = 4'd1;
    localparam logic [3:0] ST_MY   = 4'd2;
    localparam logic [3:0] ST_MP   = 4'd3;
    localparam logic [3:0] ST_GAP  = 4'd4;
    localparam logic [3:0] ST_MSQ  = 4'd5;
    localparam logic [3:0] ST_MLHS = 4'd6;
    localparam logic [3:0] ST_MRHS = 4'd7;
    localparam logic [3:0] ST_ACC  = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    logic [3:0]                      state_reg, state_next;
    logic                            launched_reg, launched_next;

    // Histogram pipeline
    logic                            s1_valid_reg;
    mot_pkg::q_item_t                s1_item_reg;
    logic                            fw_valid_reg;
    logic [mot_pkg::PIX_W-1:0]       fw_addr_reg;
    logic [mot_pkg::COUNT_BITS-1:0]  fw_data_reg;
    logic [mot_pkg::NUM_BINS-1:0]    bin_valid_reg, bin_valid_next;
    logic [mot_pkg::COUNT_BITS-1:0]  rd_data;
    logic [mot_pkg::PIX_W-1:0]       rd_addr;
    logic [mot_pkg::COUNT_BITS-1:0]  old_bin;
    logic [mot_pkg::COUNT_BITS-1:0]  new_bin;
    logic                            wr_en;

    // Image totals and scan state
    logic [mot_pkg::COUNT_BITS-1:0]  total_reg, total_next;
    logic [mot_pkg::SUM_W-1:0]       sum_reg, sum_next;
    logic [mot_pkg::COUNT_BITS-1:0]  below_reg, below_next;
    logic [mot_pkg::SUM_W-1:0]       below_sum_reg, below_sum_next;
    logic [mot_pkg::PIX_W-1:0]       t_reg, t_next;
    logic [mot_pkg::GAP_W-1:0]       x_reg, x_next;
    logic [mot_pkg::GAP_W-1:0]       y_reg, y_next;
    logic [mot_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic [mot_pkg::GAP_W-1:0]       gap_reg, gap_next;
    logic [mot_pkg::SQ_W-1:0]        gap_sq_reg, gap_sq_next;
    logic [mot_pkg::CMP_W-1:0]       lhs_reg, lhs_next;
    logic [mot_pkg::SQ_W-1:0]        best_sq_reg, best_sq_next;
    logic [mot_pkg::PROD_W-1:0]      best_prod_reg, best_prod_next;
    logic [mot_pkg::PIX_W-1:0]       best_level_reg, best_level_next;
    logic                            done_reg, done_next;
    logic [mot_pkg::PIX_W-1:0]       threshold_reg, threshold_next;
    logic                            empty_reg, empty_next;

    logic [mot_pkg::COUNT_BITS-1:0]  n1;
    logic [mot_pkg::SUM_W-1:0]       s1;
    logic [mot_pkg::COUNT_BITS-1:0]  scan_bin;
    logic [mot_pkg::SUM_W-1:0]       bin_weighted;
    logic [mot_pkg::COUNT_BITS-1:0]  total_inc;
    logic [mot_pkg::SUM_W-1:0]       sum_inc;

    // Shared multiplier
    logic                            mul_start;
    logic                            mul_done;
    logic [mot_pkg::SQ_W-1:0]        mul_a;
    logic [mot_pkg::GAP_W-1:0]       mul_b;
    logic [mot_pkg::CMP_W-1:0]       mul_p;
    logic                            mul_state;

    assign done       = done_reg;
    assign threshold  = threshold_reg;
    assign empty_mask = empty_reg;
    assign scan_done  = (state_reg == ST_DONE);

    // Pop one item a cycle while building the histogram, holding off behind a last item
    assign q_pop   = (state_reg == ST_HIST) && q_valid && !(s1_valid_reg && s1_item_reg.last);
    assign rd_addr = (state_reg == ST_HIST) ? q_item.pixel : t_reg;

    mot_ram #(
        .WIDTH (mot_pkg::COUNT_BITS),
        .DEPTH (mot_pkg::NUM_BINS)
    ) u_hist (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_item_reg.pixel),
        .wdata (new_bin),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Forward the previous write over stale read data; unwritten bins read zero
    always_comb
    begin
        if (fw_valid_reg && (fw_addr_reg == s1_item_reg.pixel))
        begin
            old_bin = fw_data_reg;
        end
        else if (bin_valid_reg[s1_item_reg.pixel])
        begin
            old_bin = rd_data;
        end
        else
        begin
            old_bin = '0;
        end
    end

    assign new_bin      = old_bin + 1'b1;
    assign wr_en        = s1_valid_reg && s1_item_reg.count;
    assign total_inc    = wr_en ? total_reg + 1'b1 : total_reg;
    assign sum_inc      = wr_en ? sum_reg + mot_pkg::SUM_W'(s1_item_reg.pixel) : sum_reg;

    // Class 1 totals and the bin under the scan
    assign n1           = total_reg - below_reg;
    assign s1           = sum_reg - below_sum_reg;
    assign scan_bin     = bin_valid_reg[t_reg] ? rd_data : '0;
    assign bin_weighted = mot_pkg::SUM_W'(scan_bin) * mot_pkg::SUM_W'(t_reg);

    // Select multiplier operands for the step in progress
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        mul_state = 1'b1;
        unique case (state_reg)
            ST_MX:
            begin
                mul_a = mot_pkg::SQ_W'(below_sum_reg);
                mul_b = mot_pkg::GAP_W'(n1);
            end
            ST_MY:
            begin
                mul_a = mot_pkg::SQ_W'(s1);
                mul_b = mot_pkg::GAP_W'(below_reg);
            end
            ST_MP:
            begin
                mul_a = mot_pkg::SQ_W'(below_reg);
                mul_b = mot_pkg::GAP_W'(n1);
            end
            ST_MSQ:
            begin
                mul_a = mot_pkg::SQ_W'(gap_reg);
                mul_b = gap_reg;
            end
            ST_MLHS:
            begin
                mul_a = gap_sq_reg;
                mul_b = mot_pkg::GAP_W'(best_prod_reg);
            end
            ST_MRHS:
            begin
                mul_a = best_sq_reg;
                mul_b = mot_pkg::GAP_W'(prod_reg);
            end
            default:
            begin
                mul_state = 1'b0;
            end
        endcase
    end

    assign mul_start = mul_state && !launched_reg;

    mot_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // Sequence histogram fill, threshold scan and result
    always_comb
    begin
        state_next      = state_reg;
        launched_next   = launched_reg;
        if (mul_done)
        begin
            launched_next = 1'b0;
        end
        else if (mul_start)
        begin
            launched_next = 1'b1;
        end
        bin_valid_next  = bin_valid_reg;
        if (wr_en)
        begin
            bin_valid_next[s1_item_reg.pixel] = 1'b1;
        end
        total_next      = total_inc;
        sum_next        = sum_inc;
        below_next      = below_reg;
        below_sum_next  = below_sum_reg;
        t_next          = t_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        prod_next       = prod_reg;
        gap_next        = gap_reg;
        gap_sq_next     = gap_sq_reg;
        lhs_next        = lhs_reg;
        best_sq_next    = best_sq_reg;
        best_prod_next  = best_prod_reg;
        best_level_next = best_level_reg;
        done_next       = 1'b0;
        threshold_next  = threshold_reg;
        empty_next      = empty_reg;

        unique case (state_reg)
            ST_HIST:
            begin
                if (s1_valid_reg && s1_item_reg.last)
                begin
                    below_next      = '0;
                    below_sum_next  = '0;
                    best_sq_next    = '0;
                    best_prod_next  = mot_pkg::PROD_W'(1);
                    best_level_next = '0;
                    t_next          = '0;
                    state_next      = (total_inc == '0) ? ST_DONE : ST_MX;
                end
            end
            ST_MX:
            begin
                if (mul_done)
                begin
                    x_next     = mot_pkg::GAP_W'(mul_p);
                    state_next = ST_MY;
                end
            end
            ST_MY:
            begin
                if (mul_done)
                begin
                    y_next     = mot_pkg::GAP_W'(mul_p);
                    state_next = ST_MP;
                end
            end
            ST_MP:
            begin
                if (mul_done)
                begin
                    prod_next  = mot_pkg::PROD_W'(mul_p);
                    state_next = ST_GAP;
                end
            end
            ST_GAP:
            begin
                gap_next   = (x_reg >= y_reg) ? x_reg - y_reg : y_reg - x_reg;
                state_next = ST_MSQ;
            end
            ST_MSQ:
            begin
                if (mul_done)
                begin
                    gap_sq_next = mot_pkg::SQ_W'(mul_p);
                    state_next  = ST_MLHS;
                end
            end
            ST_MLHS:
            begin
                if (mul_done)
                begin
                    lhs_next   = mul_p;
                    state_next = ST_MRHS;
                end
            end
            ST_MRHS:
            begin
                // Keep the first threshold with strictly greater variance
                if (mul_done)
                begin
                    if (lhs_reg > mul_p)
                    begin
                        best_sq_next    = gap_sq_reg;
                        best_prod_next  = prod_reg;
                        best_level_next = t_reg;
                    end
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                below_next     = below_reg + scan_bin;
                below_sum_next = below_sum_reg + bin_weighted;
                if (t_reg == mot_pkg::PIX_W'(mot_pkg::NUM_BINS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    t_next     = t_reg + 1'b1;
                    state_next = ST_MX;
                end
            end
            ST_DONE:
            begin
                done_next      = 1'b1;
                empty_next     = (total_reg == '0);
                threshold_next = (total_reg == '0) ? '0 : best_level_reg;
                total_next     = '0;
                sum_next       = '0;
                bin_valid_next = '0;
                state_next     = ST_HIST;
            end
            default:
            begin
                state_next = ST_HIST;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_HIST;
            launched_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            fw_valid_reg   <= 1'b0;
            bin_valid_reg  <= '0;
            total_reg      <= '0;
            sum_reg        <= '0;
            below_reg      <= '0;
            below_sum_reg  <= '0;
            t_reg          <= '0;
            best_sq_reg    <= '0;
            best_prod_reg  <= mot_pkg::PROD_W'(1);
            best_level_reg <= '0;
            done_reg       <= 1'b0;
            threshold_reg  <= '0;
            empty_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            launched_reg   <= launched_next;
            s1_valid_reg   <= q_pop;
            fw_valid_reg   <= wr_en;
            bin_valid_reg  <= bin_valid_next;
            total_reg      <= total_next;
            sum_reg        <= sum_next;
            below_reg      <= below_next;
            below_sum_reg  <= below_sum_next;
            t_reg          <= t_next;
            best_sq_reg    <= best_sq_next;
            best_prod_reg  <= best_prod_next;
            best_level_reg <= best_level_next;
            done_reg       <= done_next;
            threshold_reg  <= threshold_next;
            empty_reg      <= empty_next;
        end
    end

    // Scan datapath and pipeline payload
    always_ff @(posedge clk)
    begin
        s1_item_reg <= q_item;
        fw_addr_reg <= s1_item_reg.pixel;
        fw_data_reg <= new_bin;
        x_reg       <= x_next;
        y_reg       <= y_next;
        prod_reg    <= prod_next;
        gap_reg     <= gap_next;
        gap_sq_reg  <= gap_sq_next;
        lhs_reg     <= lhs_next;
    end

`ifndef SYNTHESIS
    a_pop_only_in_hist: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_HIST))
        else $error("queue popped outside histogram fill");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    a_mul_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MX || state_reg == ST_MY || state_reg == ST_MP ||
                      state_reg == ST_MSQ || state_reg == ST_MLHS || state_reg == ST_MRHS))
        else $error("multiplier finished outside a multiply step");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && empty_reg) |-> (threshold_reg == '0))
        else $error("empty mask result with nonzero threshold");
`endif

endmodule
`default_nettype wire

@@ tb/tb_masked_otsu_threshold_core.sv @@
// Self-checking testbench for masked_otsu_threshold_core: drives pixel commands,
// predicts each threshold with an exact integer Otsu scan, checks every done strobe.
// Depends on mot_pkg and the core RTL only.
`default_nettype none
module tb_masked_otsu_threshold_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [mot_pkg::PIX_W-1:0] threshold;
        logic                      empty_mask;
    } otsu_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [mot_pkg::PIX_W-1:0] pixel;
    logic                      in_mask;
    logic                      last_pixel;
    logic                      done;
    logic [mot_pkg::PIX_W-1:0] threshold;
    logic                      empty_mask;

    // Histogram mirror and pending thresholds
    longint unsigned hist_bins [mot_pkg::NUM_BINS];
    longint unsigned hist_total;
    longint unsigned hist_sum;
    otsu_result_t    pending_thresholds [$];
    int              fail_count;
    int              pixels_sent;

    masked_otsu_threshold_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .pixel      (pixel),
        .in_mask    (in_mask),
        .last_pixel (last_pixel),
        .done       (done),
        .threshold  (threshold),
        .empty_mask (empty_mask)
    );

    // Free-running clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Reset the histogram mirror
    function automatic void clear_histogram();
        for (int i = 0; i < mot_pkg::NUM_BINS; i++)
            hist_bins[i] = 0;
        hist_total = 0;
        hist_sum   = 0;
    endfunction

    // Exact scan: first t maximizing gap^2/(n0*n1), compared cross-multiplied
    function automatic otsu_result_t scan_best_threshold();
        otsu_result_t    res;
        longint unsigned n0, s0, n1, s1, x, y, gap, prod;
        longint unsigned top_gap, top_prod;
        logic [255:0]    lhs, rhs;
        res.threshold  = '0;
        res.empty_mask = (hist_total == 0);
        n0 = 0;
        s0 = 0;
        top_gap  = 0;
        top_prod = 1;
        if (hist_total != 0)
        begin
            for (int t = 0; t < mot_pkg::NUM_BINS; t++)
            begin
                n1   = hist_total - n0;
                s1   = hist_sum - s0;
                x    = n1 * s0;
                y    = n0 * s1;
                gap  = (x >= y) ? x - y : y - x;
                prod = n0 * n1;
                lhs  = 256'(gap) * 256'(gap) * 256'(top_prod);
                rhs  = 256'(top_gap) * 256'(top_gap) * 256'(prod);
                if (lhs > rhs)
                begin
                    top_gap       = gap;
                    top_prod      = prod;
                    res.threshold = mot_pkg::PIX_W'(t);
                end
                n0 += hist_bins[t];
                s0 += hist_bins[t] * longint'(t);
            end
        end
        return res;
    endfunction

    // Apply one accepted pixel to the mirror
    function automatic void absorb_pixel(logic [mot_pkg::PIX_W-1:0] p, logic m, logic l);
        if (m && hist_total < longint'(mot_pkg::COUNT_MAX))
        begin
            hist_bins[p]++;
            hist_total++;
            hist_sum += p;
        end
        if (l)
        begin
            pending_thresholds = {pending_thresholds, scan_best_threshold()};
            clear_histogram();
        end
    endfunction

    // Send one pixel command; called and returns at a falling edge
    task automatic send_pixel(logic [mot_pkg::PIX_W-1:0] p, logic m, logic l, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      <= 1'b1;
        pixel      <= p;
        in_mask    <= m;
        last_pixel <= l;
        do
            @(posedge clk);
        while (busy);
        absorb_pixel(p, m, l);
        pixels_sent++;
        @(negedge clk);
    endtask

    // Hold the sender until every pending threshold has been seen
    task automatic wait_drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_thresholds.size() != 0);
    endtask

    // Check each done strobe against the oldest prediction
    always @(posedge clk)
    begin
        otsu_result_t exp_res;
        if (rst_n && done)
        begin
            if (pending_thresholds.size() == 0)
            begin
                $error("unexpected result: threshold %0d empty_mask %0b", threshold, empty_mask);
                fail_count++;
            end
            else
            begin
                exp_res = pending_thresholds.pop_front();
                if (threshold !== exp_res.threshold)
                begin
                    $error("threshold: expected %0d, actual %0d", exp_res.threshold, threshold);
                    fail_count++;
                end
                if (empty_mask !== exp_res.empty_mask)
                begin
                    $error("empty_mask: expected %0b, actual %0b",
                           exp_res.empty_mask, empty_mask);
                    fail_count++;
                end
            end
        end
    end

    // Empty mask: unmasked pixels only, and a lone last pixel
    task automatic test_empty_mask();
        send_pixel(8'd17, 1'b0, 1'b0, 0);
        send_pixel(8'd255, 1'b0, 1'b0, 0);
        send_pixel(8'd0, 1'b0, 1'b1, 0);
        send_pixel(8'd99, 1'b0, 1'b1, 2);
    endtask

    // All counted pixels equal: no positive variance
    task automatic test_flat_image();
        send_pixel(8'd128, 1'b1, 1'b0, 0);
        send_pixel(8'd128, 1'b1, 1'b0, 1);
        send_pixel(8'd3, 1'b0, 1'b0, 0);
        send_pixel(8'd128, 1'b1, 1'b1, 0);
        send_pixel(8'd255, 1'b1, 1'b1, 0);
        send_pixel(8'd0, 1'b1, 1'b1, 0);
    endtask

    // Extremes 0 and 255: every split ties, lowest wins; unmasked last pixel
    task automatic test_extremes_and_ties();
        send_pixel(8'd0, 1'b1, 1'b0, 0);
        send_pixel(8'd255, 1'b1, 1'b1, 0);
        send_pixel(8'd255, 1'b1, 1'b0, 3);
        send_pixel(8'd0, 1'b1, 1'b0, 0);
        send_pixel(8'd7, 1'b0, 1'b1, 0);
        send_pixel(8'd10, 1'b1, 1'b0, 0);
        send_pixel(8'd20, 1'b1, 1'b0, 0);
        send_pixel(8'd30, 1'b1, 1'b0, 0);
        send_pixel(8'd40, 1'b1, 1'b1, 0);
        send_pixel(8'hAA, 1'b1, 1'b0, 0);
        send_pixel(8'h55, 1'b1, 1'b1, 0);
        wait_drain();
    endtask

    // Random images: two clusters with noise, mostly masked, short lengths
    task automatic test_random_images(int pixel_budget);
        int         len, gap, c0, c1, spread, v;
        bit         burst;
        logic [7:0] p;
        while (pixels_sent < pixel_budget)
        begin
            len    = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 120)
                                                   : $urandom_range(1, 40);
            c0     = $urandom_range(0, 255);
            c1     = $urandom_range(0, 255);
            spread = $urandom_range(0, 40);
            burst  = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 7) == 0)
                    v = $urandom_range(0, 255);
                else
                    v = ($urandom_range(0, 1) ? c0 : c1)
                        + $urandom_range(0, spread) - spread / 2;
                p   = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
                gap = burst ? 0 : $urandom_range(0, 10);
                send_pixel(p, $urandom_range(0, 9) != 0, i == len - 1, gap);
            end
            if ($urandom_range(0, 9) == 0)
                wait_drain();
        end
    endtask

    // Sequence the run
    initial
    begin
        clear_histogram();
        fail_count  = 0;
        pixels_sent = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        pixel       = '0;
        in_mask     = 1'b0;
        last_pixel  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_mask();
        test_flat_image();
        test_extremes_and_ties();
        test_random_images(950);

        wait_drain();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("tb_masked_otsu_threshold_core passed");
        else
            $display("tb_masked_otsu_threshold_core failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4s;
        $display("tb_masked_otsu_threshold_core failed");
        $finish;
    end

endmodule
`default_nettype wire
